[hw/rtl/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared constants, controller/datapath interface types and the key hash
// for the trace record dictionary.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int IN_KEY_W   = 64;
  localparam int KEY_BITS   = 64;
  localparam int MAX_IDS    = 16384;
  localparam int ID_W       = $clog2(MAX_IDS + 1);
  localparam int ENTRY_ID_W = 15;
  localparam int COUNT_W    = 32;
  localparam int TBL_AW     = $clog2(MAX_IDS);
  localparam int TBL_DEPTH  = 1 << TBL_AW;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic clear;
    logic load;
    logic hash_rd;
    logic advance;
    logic insert;
    logic overflow;
    logic cnt_rd;
    logic cnt_upd;
  } trd_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty;
    logic match;
    logic full;
    logic last_probe;
    logic out_free;
  } trd_stat_t;

  // XOR fold of the key onto the table index
  function automatic logic [TBL_AW-1:0] key_hash(input logic [KEY_BITS-1:0] key);
    logic [TBL_AW-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      h[i % TBL_AW] = h[i % TBL_AW] ^ key[i];
    end
    return h;
  endfunction

endpackage

[hw/rtl/trace_record_dictionary_top.sv]
// ----------------------------------------------------------------------------
// trace_record_dictionary_top
// Exact-match dictionary encoder with saturating per-key occurrence counts.
//
// Input channel (in_valid/in_ready/in_record_key): one key per transaction.
// Output channel (out_valid/out_ready/out_*): exactly one result per key,
// in order: identifier (1 up, order of first appearance), new-entry flag,
// count after update, and an overflow flag when a new key meets a full
// dictionary (identifier 0, count 0, nothing stored).
// Keys live in a linear-probed hash table; each probe is one synchronous
// read of the key and id tables. A known key adds a count state (extra
// read-modify-write of the count memory); each collision step returns to
// the probe state. One key is in flight at a time; the next is taken as
// soon as the previous result sits in the output register.
// Reset: after rst_n the table valid field is cleared one entry per cycle,
// 16384 cycles, with in_ready low. A stalled receiver holds the result in
// the output register; a finished key is written back only once it frees.
// ----------------------------------------------------------------------------
module trace_record_dictionary_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [trd_pkg::IN_KEY_W-1:0]      in_record_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [trd_pkg::ENTRY_ID_W-1:0]    out_entry_id,
  output logic                              out_is_new,
  output logic [trd_pkg::COUNT_W-1:0]       out_occurrences,
  output logic                              out_overflow
);

  trd_pkg::trd_cmd_t  cmd;
  trd_pkg::trd_stat_t stat;

  trd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_record_key   (in_record_key),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_entry_id    (out_entry_id),
    .out_is_new      (out_is_new),
    .out_occurrences (out_occurrences),
    .out_overflow    (out_overflow)
  );

endmodule

[hw/rtl/trd_ctrl.sv]
// ----------------------------------------------------------------------------
// trd_ctrl
// Sequencer for the dictionary: table clear after reset, hash probe,
// key check, count read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module trd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  trd_pkg::trd_stat_t stat,
  output trd_pkg::trd_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_COUNT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.hash_rd = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (stat.match) begin
          cmd.cnt_rd = 1'b1;
          state_nxt  = S_COUNT;
        end else if (stat.empty && !stat.full) begin
          if (stat.out_free) begin
            cmd.insert = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (stat.empty || stat.last_probe) begin
          if (stat.out_free) begin
            cmd.overflow = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_PROBE;
        end
      end
      S_COUNT: begin
        if (stat.out_free) begin
          cmd.cnt_upd = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/trd_dp.sv]
// ----------------------------------------------------------------------------
// trd_dp
// Datapath: open-addressed hash table of {key, id}, count memory indexed
// by id - 1, identifier allocator and the output register.
// ----------------------------------------------------------------------------
module trd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trd_pkg::trd_cmd_t                 cmd,
  output trd_pkg::trd_stat_t                stat,
  input  logic [trd_pkg::IN_KEY_W-1:0]      in_record_key,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [trd_pkg::ENTRY_ID_W-1:0]    out_entry_id,
  output logic                              out_is_new,
  output logic [trd_pkg::COUNT_W-1:0]       out_occurrences,
  output logic                              out_overflow
);

  logic [trd_pkg::KEY_BITS-1:0] key_mem [trd_pkg::TBL_DEPTH];
  logic [trd_pkg::ID_W-1:0]     id_mem  [trd_pkg::TBL_DEPTH];
  logic [trd_pkg::COUNT_W-1:0]  cnt_mem [trd_pkg::MAX_IDS];

  logic [trd_pkg::TBL_AW-1:0]   clr_addr_r;
  logic [trd_pkg::KEY_BITS-1:0] key_r;
  logic [trd_pkg::TBL_AW-1:0]   probe_addr_r;
  logic [trd_pkg::TBL_AW-1:0]   probe_cnt_r;
  logic [trd_pkg::ID_W-1:0]     next_id_r;
  logic [trd_pkg::ID_W-1:0]     hit_id_r;
  logic [trd_pkg::KEY_BITS-1:0] hrd_key_r;
  logic [trd_pkg::ID_W-1:0]     hrd_id_r;
  logic [trd_pkg::COUNT_W-1:0]  crd_r;

  logic                            out_valid_r;
  logic [trd_pkg::ENTRY_ID_W-1:0]  out_id_r;
  logic                            out_new_r;
  logic [trd_pkg::COUNT_W-1:0]     out_occ_r;
  logic                            out_ovf_r;

  logic [trd_pkg::ID_W-1:0]    new_id;
  logic [trd_pkg::TBL_AW-1:0]  rd_slot;
  logic [trd_pkg::TBL_AW-1:0]  hit_slot;
  logic [trd_pkg::COUNT_W-1:0] cnt_nxt;

  assign new_id   = next_id_r + trd_pkg::ID_W'(1);
  assign rd_slot  = trd_pkg::TBL_AW'(hrd_id_r - trd_pkg::ID_W'(1));
  assign hit_slot = trd_pkg::TBL_AW'(hit_id_r - trd_pkg::ID_W'(1));
  assign cnt_nxt  = (crd_r == trd_pkg::COUNT_MAX) ? crd_r
                                                  : crd_r + trd_pkg::COUNT_W'(1);

  always_comb begin
    stat.clear_last = (clr_addr_r == trd_pkg::TBL_AW'(trd_pkg::TBL_DEPTH - 1));
    stat.empty      = (hrd_id_r == '0);
    stat.match      = (hrd_id_r != '0) && (hrd_key_r == key_r);
    stat.full       = (next_id_r == trd_pkg::ID_W'(trd_pkg::MAX_IDS));
    stat.last_probe = (probe_cnt_r == trd_pkg::TBL_AW'(trd_pkg::TBL_DEPTH - 1));
    stat.out_free   = !out_valid_r || out_ready;
  end

  // hash table, id half (cleared after reset)
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      id_mem[clr_addr_r] <= '0;
    end else if (cmd.insert) begin
      id_mem[probe_addr_r] <= new_id;
    end
    if (cmd.hash_rd) begin
      hrd_id_r <= id_mem[probe_addr_r];
    end
  end

  // hash table, key half
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_mem[probe_addr_r] <= key_r;
    end
    if (cmd.hash_rd) begin
      hrd_key_r <= key_mem[probe_addr_r];
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      cnt_mem[next_id_r[trd_pkg::TBL_AW-1:0]] <= trd_pkg::COUNT_W'(1);
    end else if (cmd.cnt_upd) begin
      cnt_mem[hit_slot] <= cnt_nxt;
    end
    if (cmd.cnt_rd) begin
      crd_r <= cnt_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r        <= in_record_key[trd_pkg::KEY_BITS-1:0];
      probe_addr_r <= trd_pkg::key_hash(in_record_key[trd_pkg::KEY_BITS-1:0]);
      probe_cnt_r  <= '0;
    end else if (cmd.advance) begin
      probe_addr_r <= probe_addr_r + trd_pkg::TBL_AW'(1);
      probe_cnt_r  <= probe_cnt_r + trd_pkg::TBL_AW'(1);
    end
    if (cmd.cnt_rd) begin
      hit_id_r <= hrd_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      next_id_r  <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + trd_pkg::TBL_AW'(1);
      end
      if (cmd.insert) begin
        next_id_r <= new_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.insert || cmd.overflow || cmd.cnt_upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      out_id_r  <= trd_pkg::ENTRY_ID_W'(new_id);
      out_new_r <= 1'b1;
      out_occ_r <= trd_pkg::COUNT_W'(1);
      out_ovf_r <= 1'b0;
    end else if (cmd.overflow) begin
      out_id_r  <= '0;
      out_new_r <= 1'b0;
      out_occ_r <= '0;
      out_ovf_r <= 1'b1;
    end else if (cmd.cnt_upd) begin
      out_id_r  <= trd_pkg::ENTRY_ID_W'(hit_id_r);
      out_new_r <= 1'b0;
      out_occ_r <= cnt_nxt;
      out_ovf_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_id    = out_id_r;
  assign out_is_new      = out_new_r;
  assign out_occurrences = out_occ_r;
  assign out_overflow    = out_ovf_r;

endmodule
